>>> rtl/rrv_pkg.sv
// Shared types, constants and lookup tables for the rounded rectangle vertex generator.
// No dependencies.
`timescale 1ns / 1ps

package rrv_pkg;

  localparam int IDX_W       = 8;
  localparam int PREC_W      = 6;
  localparam int CFG_W       = 16;
  localparam int REG_IDX_W   = 8;
  localparam int CW          = 33;  // CORDIC datapath, signed Q2.30 plus guard
  localparam int PHASE_FRAC  = 30;
  localparam int TABLE_LEN   = 24;
  localparam int RECIP_SHIFT = 21;
  localparam int SUM_W       = 18;  // widest unsaturated coordinate
  localparam int PREC_DEPTH  = 1 << PREC_W;

  localparam logic [CW-1:0] CORDIC_X0 = CW'(652032874);

  // register indexes of the config port
  localparam logic [REG_IDX_W-1:0] REG_WIDTH     = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_RADIUS    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_PRECISION = REG_IDX_W'(3);

  // atan(2^-i), 2^32 units per turn
  typedef logic [29:0] atan_tab_t [TABLE_LEN];
  localparam atan_tab_t ATAN = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef logic [30:0] qtab_t [PREC_DEPTH];
  typedef logic [PREC_W-1:0] rtab_t [PREC_DEPTH];
  typedef logic [RECIP_SHIFT:0] ctab_t [PREC_DEPTH];

  // long division used only while building the tables
  function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] den,
                                            bit want_rem);
    logic [63:0] quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return want_rem ? rem : quo;
  endfunction

  // floor(2^30 / p)
  function automatic qtab_t build_qtab();
    qtab_t t;
    t[0] = '0;
    for (int k = 1; k < PREC_DEPTH; k++)
      t[k] = 31'(const_div(64'd1 << 30, 64'(k), 1'b0));
    return t;
  endfunction

  // 2^30 mod p
  function automatic rtab_t build_rtab();
    rtab_t t;
    t[0] = '0;
    for (int k = 1; k < PREC_DEPTH; k++)
      t[k] = PREC_W'(const_div(64'd1 << 30, 64'(k), 1'b1));
    return t;
  endfunction

  // ceil(2^21 / p), exact reciprocal for 14-bit dividends
  function automatic ctab_t build_ctab();
    ctab_t t;
    t[0] = '0;
    for (int k = 1; k < PREC_DEPTH; k++)
      t[k] = (RECIP_SHIFT+1)'(const_div((64'd1 << RECIP_SHIFT) + 64'(k) - 64'd1,
                                        64'(k), 1'b0));
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();
  localparam rtab_t RTAB = build_rtab();
  localparam ctab_t CTAB = build_ctab();

  // sideband that rides along with each word
  typedef struct packed {
    logic       in_range;
    logic       sharp;
    logic [1:0] quad;  // rectangle corner
    logic [1:0] turn;  // quarter turn of the angle
  } side_t;

endpackage

>>> rtl/rounded_rect_vertex_gen.sv
// Top level of the rounded rectangle vertex generator: config registers and pipeline.
// Depends on rrv_pkg, rrv_front, rrv_cordic, rrv_back.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, always ready) writes width, height,
//   corner_radius and arc_precision by index 0..3; other indexes are ignored.
//   Write config only while no word is in flight.
//   Input channel (in_valid/in_stall) takes one point_index word per cycle when not stalled.
//   Output channel (out_valid/out_stall) returns pos_x, pos_y, index_in_range
//   for each input word, in order.
// Pipeline: index decode and phase division by reciprocal tables, then a
//   registered stage per CORDIC iteration, then scaling and offset ending in
//   the output register.
// Throughput: one word per cycle while the output is not stalled.
// Stall: the whole pipeline freezes while a finished word sits in the output
//   register and out_stall is high; in_stall is raised for that time. Nothing
//   is dropped or repeated.
// Reset: clears the config registers to zero and all pipeline valid bits.
`timescale 1ns / 1ps

module rounded_rect_vertex_gen import rrv_pkg::*; #(
  parameter int MAX_PRECISION = 63,
  parameter int COORD_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IDX_W-1:0]      point_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] pos_x,
  output logic [COORD_BITS-1:0] pos_y,
  output logic                  index_in_range
);

  logic [CFG_W-1:0]  width, height, corner_radius;
  logic [PREC_W-1:0] arc_precision;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width         <= '0;
      height        <= '0;
      corner_radius <= '0;
      arc_precision <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:     width         <= cfg_data;
        REG_HEIGHT:    height        <= cfg_data;
        REG_RADIUS:    corner_radius <= cfg_data;
        REG_PRECISION: arc_precision <= cfg_data[PREC_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: hold everything only when the output word is stuck
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic                 f_valid, c_valid;
  side_t                f_side, c_side;
  logic [29:0]          f_z;
  logic signed [CW-1:0] c_x, c_y;

  rrv_front #(
    .MAX_PRECISION(MAX_PRECISION)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .point_index(point_index),
    .precision  (arc_precision),
    .out_valid  (f_valid),
    .out_side   (f_side),
    .out_z      (f_z)
  );

  rrv_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (f_valid),
    .in_side  (f_side),
    .in_z     (f_z),
    .out_valid(c_valid),
    .out_side (c_side),
    .out_x    (c_x),
    .out_y    (c_y)
  );

  rrv_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (c_valid),
    .in_side       (c_side),
    .in_x          (c_x),
    .in_y          (c_y),
    .width         (width),
    .height        (height),
    .corner_radius (corner_radius),
    .out_valid     (out_valid),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .index_in_range(index_in_range)
  );

endmodule

>>> rtl/rrv_front.sv
// Index decode and angle phase: quadrant, arc index and a*2^30/p rounded.
// Depends on rrv_pkg.
`timescale 1ns / 1ps

module rrv_front import rrv_pkg::*; #(
  parameter int MAX_PRECISION = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [IDX_W-1:0]  point_index,
  input  logic [PREC_W-1:0] precision,
  output logic              out_valid,
  output side_t             out_side,
  output logic [29:0]       out_z
);

  // stage 1 comb
  logic [7:0]        p8;
  logic [PREC_W-1:0] p;
  logic [8:0]        pp1, t2, t3, cnt, idx9;
  logic [1:0]        q;
  side_t             side1_next;

  always_comb begin
    p8   = (8'(precision) > 8'(MAX_PRECISION)) ? 8'(MAX_PRECISION) : 8'(precision);
    p    = p8[PREC_W-1:0];
    pp1  = 9'(p) + 9'd1;
    t2   = pp1 << 1;
    t3   = pp1 + t2;
    cnt  = pp1 << 2;
    idx9 = 9'(point_index);
    q    = 2'(idx9 >= pp1) + 2'(idx9 >= t2) + 2'(idx9 >= t3);
    side1_next.in_range = idx9 < cnt;
    side1_next.sharp    = p == '0;
    side1_next.quad     = q;
    side1_next.turn     = '0;
  end

  logic              v1, v2, v3, v4;
  side_t             side1, side2, side3, side4;
  logic [7:0]        a1;
  logic [PREC_W-1:0] p1, p2;
  logic [31:0]       prod2, prod3;
  logic [13:0]       m2;
  logic [7:0]        qd3;
  logic [29:0]       z4;

  logic [38:0]       prod_full;
  logic [RECIP_SHIFT+14:0] recip_full;
  logic [31:0]       phase;

  always_comb begin
    prod_full  = 39'(a1) * 39'(QTAB[p1]);
    recip_full = (RECIP_SHIFT+15)'(m2) * (RECIP_SHIFT+15)'(CTAB[p2]);
    phase      = prod3 + 32'(qd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1 <= side1_next;
      a1    <= point_index - 8'(q);
      p1    <= p;

      side2 <= side1;
      p2    <= p1;
      prod2 <= prod_full[31:0];
      // remainder part: a*(2^30 mod p) + p/2, divided next stage
      m2    <= 14'(a1) * 14'(RTAB[p1]) + 14'(p1 >> 1);

      side3 <= side2;
      prod3 <= prod2;
      qd3   <= recip_full[RECIP_SHIFT+7:RECIP_SHIFT];

      side4 <= '{in_range: side3.in_range, sharp: side3.sharp, quad: side3.quad,
                 turn: phase[31:30]};
      z4    <= phase[29:0];
    end
  end

  assign out_valid = v4;
  assign out_side  = side4;
  assign out_z     = z4;

endmodule

>>> rtl/rrv_cordic.sv
// Rotation-mode CORDIC, one registered stage per iteration.
// Depends on rrv_pkg.
`timescale 1ns / 1ps

module rrv_cordic import rrv_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  side_t                in_side,
  input  logic [29:0]          in_z,
  output logic                 out_valid,
  output side_t                out_side,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y
);

  logic                 vs [STAGES+1];
  side_t                ss [STAGES+1];
  logic signed [CW-1:0] xs [STAGES+1];
  logic signed [CW-1:0] ys [STAGES+1];
  logic signed [CW-1:0] zs [STAGES+1];

  assign vs[0] = in_valid;
  assign ss[0] = in_side;
  assign xs[0] = CORDIC_X0;
  assign ys[0] = '0;
  assign zs[0] = CW'(in_z);

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy, da;
    always_comb begin
      dx = ys[i] >>> i;
      dy = xs[i] >>> i;
      da = CW'(ATAN[i]);
    end

    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else if (adv) vs[i+1] <= vs[i];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ss[i+1] <= ss[i];
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - da;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + da;
        end
      end
    end
  end

  assign out_valid = vs[STAGES];
  assign out_side  = ss[STAGES];
  assign out_x     = xs[STAGES];
  assign out_y     = ys[STAGES];

endmodule

>>> rtl/rrv_back.sv
// Quarter-turn fixup, radius scaling, corner offset and saturation.
// Depends on rrv_pkg.
`timescale 1ns / 1ps

module rrv_back import rrv_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  side_t                 in_side,
  input  logic signed [CW-1:0]  in_x,
  input  logic signed [CW-1:0]  in_y,
  input  logic [CFG_W-1:0]      width,
  input  logic [CFG_W-1:0]      height,
  input  logic [CFG_W-1:0]      corner_radius,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] pos_x,
  output logic [COORD_BITS-1:0] pos_y,
  output logic                  index_in_range
);

  // clamped radius, corner offsets; user keeps config static while words in flight, unenforced
  logic [CFG_W-1:0] side_min, r_half, rad, off_x, off_y;
  logic [CFG_W:0]   two_r;

  always_comb begin
    side_min = (width < height) ? width : height;
    r_half   = side_min >> 1;
    rad      = (corner_radius < r_half) ? corner_radius : r_half;
    two_r    = {rad, 1'b0};
    off_x    = CFG_W'((CFG_W+1)'(width) - two_r);
    off_y    = CFG_W'((CFG_W+1)'(height) - two_r);
  end

  // stage A: apply quarter turn, add one, clamp at zero
  logic signed [CW-1:0] c, s;
  logic signed [CW:0]   c1, s1;

  always_comb begin
    unique case (in_side.turn)
      2'd0: begin c = in_x;  s = in_y;  end
      2'd1: begin c = -in_y; s = in_x;  end
      2'd2: begin c = -in_x; s = -in_y; end
      default: begin c = in_y; s = -in_x; end
    endcase
    c1 = (CW+1)'(c) + ((CW+1)'(1) <<< PHASE_FRAC);
    s1 = (CW+1)'(s) + ((CW+1)'(1) <<< PHASE_FRAC);
  end

  logic        va, vb, vc;
  side_t       sa, sb;
  logic [31:0] ca, sa_v;
  logic [47:0] mxb, myb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  // stage C comb: round to Q18.0, add offset, pick sharp or off-outline values
  logic [48:0]      rx, ry;
  logic [SUM_W-1:0] sum_x, sum_y;

  always_comb begin
    rx = 49'(mxb) + (49'd1 << (PHASE_FRAC - 1));
    ry = 49'(myb) + (49'd1 << (PHASE_FRAC - 1));
    if (!sb.in_range) begin
      sum_x = '0;
      sum_y = '0;
    end else if (sb.sharp) begin
      sum_x = (sb.quad == 2'd0 || sb.quad == 2'd3) ? SUM_W'(width) : '0;
      sum_y = (sb.quad == 2'd2 || sb.quad == 2'd3) ? SUM_W'(height) : '0;
    end else begin
      sum_x = rx[PHASE_FRAC+SUM_W-1:PHASE_FRAC];
      sum_y = ry[PHASE_FRAC+SUM_W-1:PHASE_FRAC];
      if (sb.quad == 2'd0 || sb.quad == 2'd3) sum_x = sum_x + SUM_W'(off_x);
      if (sb.quad == 2'd0 || sb.quad == 2'd1) sum_y = sum_y + SUM_W'(off_y);
    end
  end

  logic [COORD_BITS-1:0] sat_x, sat_y;

  if (COORD_BITS >= SUM_W) begin : g_wide
    assign sat_x = COORD_BITS'(sum_x);
    assign sat_y = COORD_BITS'(sum_y);
  end else begin : g_sat
    assign sat_x = (|sum_x[SUM_W-1:COORD_BITS]) ? '1 : sum_x[COORD_BITS-1:0];
    assign sat_y = (|sum_y[SUM_W-1:COORD_BITS]) ? '1 : sum_y[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa   <= in_side;
      ca   <= c1[CW] ? '0 : c1[31:0];
      sa_v <= s1[CW] ? '0 : s1[31:0];

      sb  <= sa;
      mxb <= 48'(ca) * 48'(rad);
      myb <= 48'(sa_v) * 48'(rad);

      pos_x          <= sat_x;
      pos_y          <= sat_y;
      index_in_range <= sb.in_range;
    end
  end

  assign out_valid = vc;

endmodule
